/* sv/cbsa_pkg.sv */
// Shared types, codes and defaults of the chunked bitmap slot allocator.
`default_nettype none
package cbsa_pkg;

  localparam int SLOTS_PER_CHUNK_DEF = 512;
  localparam int MAX_CHUNKS_DEF      = 128;
  localparam int WORD_BITS_DEF       = 32;

  localparam int INDEX_W    = 16;
  localparam int LIVE_W     = 17;
  localparam int CHUNKS_W   = 8;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ALLOC   = 2'd0,
    STAT_FREED   = 2'd1,
    STAT_IGNORED = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_L1,
    ST_ALLOC_L0,
    ST_FREE
  } state_t;

endpackage
`default_nettype wire

/* sv/cbsa_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
`default_nettype none
module cbsa_ram
  import cbsa_pkg::*;
#(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/chunked_bitmap_slot_allocator.sv */
// Top level: first-fit slot allocator over a two-level occupancy bitmap.
// An allocate reads the summary RAM (ALLOC_L1), then the bitmap RAM (ALLOC_L0); a free reads
//   both at once (FREE). A new request is taken only in idle, after the last one's write-back
//   and registered reply; both wait while the output register still holds an untaken reply.
// Reset: synchronous; afterwards a clearing pass over all STORE_WORDS bitmap words (2048
//   with defaults) zeroes both RAMs while in_tready stays low.
`default_nettype none
module chunked_bitmap_slot_allocator
  import cbsa_pkg::*;
#(
  parameter int SLOTS_PER_CHUNK = SLOTS_PER_CHUNK_DEF,
  parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF,
  parameter int WORD_BITS       = WORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] slot_index
  input  wire logic [0:0]            in_tuser,   // [0] operation
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [15:0] granted_index, [32:16] live_slots,
                                                 // [40:33] chunks_in_use, [47:41] zero
  output logic      [STATUS_W-1:0]   out_tuser   // [1:0] status
);

  // Sizes; slot count, chunk count and word width are powers of two.
  localparam int WBL         = $clog2(WORD_BITS);
  localparam int SBL         = $clog2(SLOTS_PER_CHUNK);
  localparam int WPC         = (SLOTS_PER_CHUNK + WORD_BITS - 1) / WORD_BITS;
  localparam int WPCL        = $clog2(WPC);
  localparam int STORE_WORDS = MAX_CHUNKS * WPC;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int NL1         = (STORE_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int SAW         = (NL1 > 1) ? $clog2(NL1) : 1;
  localparam int VBITS       = (SLOTS_PER_CHUNK < WORD_BITS) ? SLOTS_PER_CHUNK : WORD_BITS;
  localparam int ENW         = $clog2(MAX_CHUNKS + 1);

  state_t               state_r, state_nxt;
  logic [AW-1:0]        clr_cnt_r, clr_cnt_nxt;
  logic [NL1-1:0]       l2_full_r, l2_full_nxt;
  logic [LIVE_W-1:0]    used_r, used_nxt;
  logic [ENW-1:0]       enab_r, enab_nxt;
  logic                 full_q_r, full_q_nxt;
  logic                 chunk_ok_r, chunk_ok_nxt;
  logic [SAW-1:0]       sidx_r, sidx_nxt;
  logic [AW-1:0]        widx_r, widx_nxt;
  logic [WBL-1:0]       jpos_r, jpos_nxt;
  logic [WBL-1:0]       bpos_r, bpos_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]   out_granted_r, out_granted_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [LIVE_W-1:0]    out_live_r;
  logic [ENW-1:0]       out_chunks_r;
  logic                 out_load;
  logic                 out_free;

  logic                 l0_we, l0_re;
  logic [AW-1:0]        l0_waddr, l0_raddr;
  logic [WORD_BITS-1:0] l0_wdata, l0_rdata;
  logic                 l1_we, l1_re;
  logic [SAW-1:0]       l1_waddr, l1_raddr;
  logic [WORD_BITS-1:0] l1_wdata, l1_rdata;

  logic [WORD_BITS-1:0] l0_vmask, l1_vmask;
  logic [WORD_BITS-1:0] l0_seen, l1_seen;
  logic [WORD_BITS-1:0] l0_set, l1_set;
  logic [WORD_BITS-1:0] l0_clr, l1_clr;
  logic                 l0_avail, l1_avail, l2_avail;
  logic [WBL-1:0]       b_sel, j_sel;
  logic [SAW-1:0]       l2_sel;
  logic                 word_full;

  // Bitmap words, one bit per slot.
  cbsa_ram #(.DEPTH(STORE_WORDS), .AW(AW), .DW(WORD_BITS)) u_bitmap (
    .clk   (clk),
    .we    (l0_we),
    .waddr (l0_waddr),
    .wdata (l0_wdata),
    .re    (l0_re),
    .raddr (l0_raddr),
    .rdata (l0_rdata)
  );

  // Summary words, one bit per full bitmap word.
  cbsa_ram #(.DEPTH(NL1), .AW(SAW), .DW(WORD_BITS)) u_summary (
    .clk   (clk),
    .we    (l1_we),
    .waddr (l1_waddr),
    .wdata (l1_wdata),
    .re    (l1_re),
    .raddr (l1_raddr),
    .rdata (l1_rdata)
  );

  // Bits past the end of a chunk or of the store count as used.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      l0_vmask[i] = (i < VBITS);
      l1_vmask[i] = (((int'(sidx_r) << WBL) + i) < STORE_WORDS);
    end
  end

  assign l0_seen = l0_rdata | ~l0_vmask;
  assign l1_seen = l1_rdata | ~l1_vmask;

  // Lowest-zero searches at each level.
  always_comb begin
    b_sel    = '0;
    j_sel    = '0;
    l0_avail = 1'b0;
    l1_avail = 1'b0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!l0_seen[i]) begin
        b_sel    = WBL'(i);
        l0_avail = 1'b1;
      end
      if (!l1_seen[i]) begin
        j_sel    = WBL'(i);
        l1_avail = 1'b1;
      end
    end
  end

  always_comb begin
    l2_sel   = '0;
    l2_avail = 1'b0;
    for (int i = NL1 - 1; i >= 0; i--) begin
      if (!l2_full_r[i]) begin
        l2_sel   = SAW'(i);
        l2_avail = 1'b1;
      end
    end
  end

  assign l0_set    = l0_rdata | (WORD_BITS'(1) << b_sel);
  assign word_full = &(l0_set | ~l0_vmask);
  assign l1_set    = l1_rdata | (WORD_BITS'(word_full) << jpos_r);
  assign l0_clr    = l0_rdata & ~(WORD_BITS'(1) << bpos_r);
  assign l1_clr    = l1_rdata & ~(WORD_BITS'(1) << jpos_r);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    int idx_i;
    int slot_i;
    int chunk_i;
    int w_i;
    int c_i;
    int slot_a;
    idx_i           = int'(in_tdata[INDEX_W-1:0]);
    slot_i          = idx_i & (SLOTS_PER_CHUNK - 1);
    chunk_i         = (idx_i >> SBL) & (MAX_CHUNKS - 1);
    w_i             = (chunk_i << WPCL) + (slot_i >> WBL);
    c_i             = int'(widx_r) >> WPCL;
    slot_a          = ((int'(widx_r) & (WPC - 1)) << WBL) | int'(b_sel);

    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    l2_full_nxt     = l2_full_r;
    used_nxt        = used_r;
    enab_nxt        = enab_r;
    full_q_nxt      = full_q_r;
    chunk_ok_nxt    = chunk_ok_r;
    sidx_nxt        = sidx_r;
    widx_nxt        = widx_r;
    jpos_nxt        = jpos_r;
    bpos_nxt        = bpos_r;
    out_load        = 1'b0;
    out_granted_nxt = '0;
    out_status_nxt  = STAT_IGNORED;
    l0_we           = 1'b0;
    l0_waddr        = widx_r;
    l0_wdata        = '0;
    l0_re           = 1'b0;
    l0_raddr        = widx_r;
    l1_we           = 1'b0;
    l1_waddr        = sidx_r;
    l1_wdata        = '0;
    l1_re           = 1'b0;
    l1_raddr        = sidx_r;

    case (state_r)
      ST_CLEAR: begin
        l0_we    = 1'b1;
        l0_waddr = clr_cnt_r;
        if (int'(clr_cnt_r) < NL1) begin
          l1_we    = 1'b1;
          l1_waddr = SAW'(clr_cnt_r);
        end
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(STORE_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0] == OP_ALLOC) begin
            l1_re      = 1'b1;
            l1_raddr   = l2_sel;
            sidx_nxt   = l2_sel;
            full_q_nxt = !l2_avail;
            state_nxt  = ST_ALLOC_L1;
          end else begin
            l0_re        = 1'b1;
            l0_raddr     = AW'(w_i);
            l1_re        = 1'b1;
            l1_raddr     = SAW'(w_i >> WBL);
            sidx_nxt     = SAW'(w_i >> WBL);
            widx_nxt     = AW'(w_i);
            jpos_nxt     = WBL'(w_i & (WORD_BITS - 1));
            bpos_nxt     = WBL'(slot_i & (WORD_BITS - 1));
            chunk_ok_nxt = (chunk_i < int'(enab_r));
            state_nxt    = ST_FREE;
          end
        end
      end
      ST_ALLOC_L1: begin
        if (full_q_r) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_status_nxt = STAT_FULL;
            enab_nxt       = ENW'(MAX_CHUNKS);
            state_nxt      = ST_IDLE;
          end
        end else begin
          l0_re     = 1'b1;
          l0_raddr  = AW'((int'(sidx_r) << WBL) | int'(j_sel));
          widx_nxt  = AW'((int'(sidx_r) << WBL) | int'(j_sel));
          jpos_nxt  = j_sel;
          state_nxt = ST_ALLOC_L0;
        end
      end
      ST_ALLOC_L0: begin
        if (out_free) begin
          l0_we                = 1'b1;
          l0_wdata             = l0_set;
          l1_we                = 1'b1;
          l1_wdata             = l1_set;
          l2_full_nxt[sidx_r]  = &(l1_set | ~l1_vmask);
          used_nxt             = used_r + LIVE_W'(1);
          if (c_i + 1 > int'(enab_r)) begin
            enab_nxt = ENW'(c_i + 1);
          end
          out_load        = 1'b1;
          out_status_nxt  = STAT_ALLOC;
          out_granted_nxt = INDEX_W'((c_i << SBL) | slot_a);
          state_nxt       = ST_IDLE;
        end
      end
      ST_FREE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (chunk_ok_r && l0_rdata[bpos_r]) begin
            l0_we               = 1'b1;
            l0_wdata            = l0_clr;
            l1_we               = 1'b1;
            l1_wdata            = l1_clr;
            l2_full_nxt[sidx_r] = 1'b0;
            used_nxt            = used_r - LIVE_W'(1);
            out_status_nxt      = STAT_FREED;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      l2_full_r   <= '0;
      used_r      <= '0;
      enab_r      <= ENW'(1);
      full_q_r    <= 1'b0;
      chunk_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      l2_full_r   <= l2_full_nxt;
      used_r      <= used_nxt;
      enab_r      <= enab_nxt;
      full_q_r    <= full_q_nxt;
      chunk_ok_r  <= chunk_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sidx_r <= sidx_nxt;
    widx_r <= widx_nxt;
    jpos_r <= jpos_nxt;
    bpos_r <= bpos_nxt;
    if (out_load) begin
      out_granted_r <= out_granted_nxt;
      out_status_r  <= out_status_nxt;
      out_live_r    <= used_nxt;
      out_chunks_r  <= enab_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, CHUNKS_W'(out_chunks_r), out_live_r, out_granted_r};

`ifndef NO_ASSERTIONS
  // A summary word picked as not full must hold a free bitmap word.
  a_summary_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALLOC_L1) && !full_q_r |-> l1_avail)
    else $error("summary word chosen with no free bitmap word");

  // A bitmap word marked not full must hold a free slot.
  a_bitmap_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALLOC_L0) |-> l0_avail)
    else $error("bitmap word chosen with no free slot");

  // A successful free lowers the live count by one.
  a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FREE) && out_free && chunk_ok_r && l0_rdata[bpos_r]
      |=> used_r == $past(used_r) - LIVE_W'(1))
    else $error("free did not decrement live count");

  // The number of chunks in use never shrinks outside reset.
  a_chunks_grow: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> enab_r >= $past(enab_r))
    else $error("chunks in use decreased");
`endif

endmodule
`default_nettype wire

/* dv/cbsa_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the slot allocator: mirrors the occupancy bitmap and checks every reply.
module cbsa_checker
  import cbsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] slot_index
  input  logic [0:0]            in_tuser,   // [0] operation
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [15:0] granted_index, [32:16] live_slots,
                                            // [40:33] chunks_in_use, [47:41] zero
  input  logic [STATUS_W-1:0]   out_tuser,  // [1:0] status
  output int                    fail_count,
  output int                    replies_outstanding
);

  localparam int SLOTS           = SLOTS_PER_CHUNK_DEF;
  localparam int CHUNKS          = MAX_CHUNKS_DEF;
  localparam int WBITS           = WORD_BITS_DEF;
  localparam int WORDS_PER_CHUNK = (SLOTS + WBITS - 1) / WBITS;
  localparam int STORE_WORDS     = CHUNKS * WORDS_PER_CHUNK;
  localparam int LIVE_LSB        = INDEX_W;
  localparam int CHUNKS_LSB      = INDEX_W + LIVE_W;
  localparam int PAD_LSB         = INDEX_W + LIVE_W + CHUNKS_W;

  typedef struct packed {
    logic [INDEX_W-1:0]  granted;
    status_t             status;
    logic [LIVE_W-1:0]   live;
    logic [CHUNKS_W-1:0] chunks;
  } reply_t;

  logic [WBITS-1:0]  occupancy [STORE_WORDS];
  int                fill_of_chunk [CHUNKS];
  int                chunks_enabled;
  logic [LIVE_W-1:0] slots_live;
  reply_t            replies_due [$];
  int                errors = 0;

  // Apply one request to the mirrored bitmap and return the reply it must produce.
  task automatic serve_request(input logic op, input logic [INDEX_W-1:0] idx,
                               output reply_t r);
    int c;
    int w;
    int b;
    int hit_chunk;
    int hit_slot;
    int word_at;
    int chunk;
    int slot;
    hit_chunk = -1;
    hit_slot  = -1;
    r.granted = '0;
    if (op == OP_ALLOC) begin
      r.status = STAT_FULL;
      // enable chunks one by one until one with room turns up
      for (c = 0; c < CHUNKS && hit_chunk < 0; c++) begin
        if (c >= chunks_enabled) chunks_enabled = c + 1;
        if (fill_of_chunk[c] < SLOTS) hit_chunk = c;
      end
      if (hit_chunk >= 0) begin
        for (w = 0; w < WORDS_PER_CHUNK && hit_slot < 0; w++) begin
          word_at = hit_chunk * WORDS_PER_CHUNK + w;
          if (occupancy[word_at] != '1) begin
            for (b = 0; b < WBITS && hit_slot < 0; b++) begin
              if (!occupancy[word_at][b]) hit_slot = w * WBITS + b;
            end
          end
        end
        word_at = hit_chunk * WORDS_PER_CHUNK + hit_slot / WBITS;
        occupancy[word_at][hit_slot % WBITS] = 1'b1;
        fill_of_chunk[hit_chunk]++;
        slots_live = slots_live + 1'b1;
        r.granted  = INDEX_W'(hit_chunk * SLOTS + hit_slot);
        r.status   = STAT_ALLOC;
      end
    end else begin
      slot    = idx % SLOTS;
      chunk   = (idx / SLOTS) % CHUNKS;
      word_at = chunk * WORDS_PER_CHUNK + slot / WBITS;
      if (chunk < chunks_enabled && occupancy[word_at][slot % WBITS]) begin
        occupancy[word_at][slot % WBITS] = 1'b0;
        fill_of_chunk[chunk]--;
        slots_live = slots_live - 1'b1;
        r.status   = STAT_FREED;
      end else begin
        r.status = STAT_IGNORED;
      end
    end
    r.live   = slots_live;
    r.chunks = CHUNKS_W'(chunks_enabled);
  endtask

  function automatic bit field_ok(string name, longint unsigned want, longint unsigned got);
    if (want != got)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    return want == got;
  endfunction

  always @(posedge clk) begin : watch
    reply_t due;
    reply_t seen;
    bit     bad;
    if (!rst_n) begin
      for (int i = 0; i < STORE_WORDS; i++) occupancy[i] = '0;
      for (int i = 0; i < CHUNKS; i++) fill_of_chunk[i] = 0;
      chunks_enabled = 1;
      slots_live     = '0;
      replies_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen.granted = out_tdata[INDEX_W-1:0];
        seen.live    = out_tdata[LIVE_LSB +: LIVE_W];
        seen.chunks  = out_tdata[CHUNKS_LSB +: CHUNKS_W];
        seen.status  = status_t'(out_tuser);
        if (replies_due.size() == 0) begin
          $display("%0t ns: reply with no request waiting, expected none, actual %0h",
                   $time, seen);
          errors++;
        end else begin
          due = replies_due.pop_front();
          bad = 1'b0;
          bad |= !field_ok("granted_index", due.granted, seen.granted);
          bad |= !field_ok("status", due.status, seen.status);
          bad |= !field_ok("live_slots", due.live, seen.live);
          bad |= !field_ok("chunks_in_use", due.chunks, seen.chunks);
          bad |= !field_ok("pad bits", 0, out_tdata[OUT_DATA_W-1:PAD_LSB]);
          if (bad) errors++;
        end
      end
      // match replies first: a reply never belongs to the request of the same edge
      if (in_tvalid && in_tready) begin
        serve_request(in_tuser[0], in_tdata, due);
        replies_due = {replies_due, due};
      end
    end
    fail_count          <= errors;
    replies_outstanding <= replies_due.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Bench top: drives allocate and free requests into the slot allocator and gives the verdict.
module tb_top;
  import cbsa_pkg::*;

  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 120;  // per random phase
  localparam int FILL_ITEMS    = 470;
  // ~740 requests with their stalls and idle gaps plus the clearing pass, several times over
  localparam longint CYCLE_LIMIT = 200_000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [15:0] slot_index
  logic [0:0]            in_tuser   = '0;   // [0] operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [15:0] granted_index, [32:16] live_slots,
                                            // [40:33] chunks_in_use, [47:41] zero
  logic [STATUS_W-1:0]   out_tuser;         // [1:0] status

  int     fail_count;
  int     replies_outstanding;
  int     burst_left  = 1;
  int     max_gap     = 8;
  int     max_burst   = 40;
  int     allocs_sent = 0;
  longint cycle_count = 0;
  logic [9:0] rx_cycle = '0;

  always #6 clk = ~clk;

  chunked_bitmap_slot_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cbsa_checker reply_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .in_tuser            (in_tuser),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .fail_count          (fail_count),
    .replies_outstanding (replies_outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: rotate through always-ready, light stalls, one-in-four and coin-flip stalls.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1'b1;
    case (rx_cycle[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      2'd2: out_tready <= (rx_cycle[1:0] == 2'd0);
      default: out_tready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Present one request, hold it until accepted, then maybe idle between bursts.
  task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx);
    int gap;
    in_tvalid   <= 1'b1;
    in_tuser[0] <= op;
    in_tdata    <= idx;
    do @(posedge clk); while (!in_tready);
    if (op == OP_ALLOC) allocs_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, max_burst);
    end
  endtask

  // Frees mostly aim at the packed low region where first-fit puts live slots.
  task automatic send_random(input int alloc_pct);
    logic [INDEX_W-1:0] idx;
    int reach;
    reach = (allocs_sent > 65535) ? 65535 : allocs_sent + 8;
    if ($urandom_range(0, 99) < 80) idx = INDEX_W'($urandom_range(0, reach));
    else idx = INDEX_W'($urandom());
    if ($urandom_range(0, 99) < alloc_pct) send_request(OP_ALLOC, idx);
    else send_request(OP_FREE, idx);
  endtask

  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int i;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // frees before anything is used, including chunks not in use, then mixed allocates and frees
    send_request(OP_FREE, 16'h0000);
    send_request(OP_FREE, 16'hFFFF);
    send_request(OP_FREE, 16'h0200);
    send_request(OP_ALLOC, 16'hFFFF);
    send_request(OP_ALLOC, 16'h0000);
    send_request(OP_ALLOC, 16'h5A5A);
    send_request(OP_ALLOC, 16'hA5A5);
    send_request(OP_FREE, 16'h0001);
    send_request(OP_ALLOC, 16'h0000);
    send_request(OP_FREE, 16'h0001);
    send_request(OP_FREE, 16'h0001);
    send_request(OP_FREE, 16'h8000);
    send_request(OP_FREE, 16'h0201);
    send_request(OP_ALLOC, 16'hFFFF);
    send_request(OP_FREE, 16'h0003);
    send_request(OP_FREE, 16'h0002);
    send_request(OP_ALLOC, 16'h0000);
    send_request(OP_ALLOC, 16'h0000);
    send_request(OP_FREE, 16'h0000);
    send_request(OP_ALLOC, 16'h0000);

    for (i = 0; i < RANDOM_ITEMS; i++) send_random(65);
    drain_replies();

    // allocate past the end of the first chunk so a second one is enabled
    max_gap   = 2;
    max_burst = 200;
    for (i = 0; i < FILL_ITEMS; i++) send_request(OP_ALLOC, INDEX_W'($urandom()));
    drain_replies();

    max_gap   = 8;
    max_burst = 40;
    send_request(OP_FREE, 16'hFFFF);
    send_request(OP_FREE, 16'h0000);
    send_request(OP_ALLOC, 16'h0000);
    send_request(OP_ALLOC, 16'h0000);
    send_request(OP_ALLOC, 16'hFFFF);
    send_request(OP_FREE, 16'hFE00);

    // churn across the chunk boundary
    for (i = 0; i < RANDOM_ITEMS; i++) send_random(50);
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
